// ===== rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Word layouts of the access and result channels, operation, target and
// mapper kind codes, and configuration register indexes.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Widths fixed by the bus and the external memories.
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned OFFS_W   = 22;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // Bus address boundaries.
    localparam logic [ADDR_W-1:0] PRG_RAM_BASE = 16'h6000;
    localparam logic [ADDR_W-1:0] PRG_ROM_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] PRG_UPPER_BASE = 16'hC000;
    localparam logic [ADDR_W-1:0] CHR_LIMIT     = 16'h2000;
    localparam logic [ADDR_W-1:0] NT_SECOND_BASE = 16'h2800;

    // Serial register: number of writes that complete one load.
    localparam logic [2:0] SERIAL_LOADS = 3'd5;

    typedef enum logic [2:0] {
        OP_CPU_READ  = 3'd0,
        OP_CPU_WRITE = 3'd1,
        OP_PPU_READ  = 3'd2,
        OP_PPU_WRITE = 3'd3,
        OP_NT_LOOKUP = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_RAM = 3'd1,
        TGT_PRG_ROM = 3'd2,
        TGT_CHR_RAM = 3'd3,
        TGT_CHR_ROM = 3'd4,
        TGT_NT_RAM  = 3'd5
    } t_target;

    typedef enum logic [1:0] {
        KIND_FIXED  = 2'd0,
        KIND_SERIAL = 2'd1,
        KIND_SWITCH = 2'd2
    } t_kind;

    // Serial register destination, chosen by address bits 14..13.
    typedef enum logic [1:0] {
        SREG_CONTROL  = 2'd0,
        SREG_CHR_LOW  = 2'd1,
        SREG_CHR_HIGH = 2'd2,
        SREG_PRG      = 2'd3
    } t_sreg;

    // Nametable mirroring arrangements.
    typedef enum logic [1:0] {
        MIR_SINGLE_LOW  = 2'd0,
        MIR_SINGLE_HIGH = 2'd1,
        MIR_VERTICAL    = 2'd2,
        MIR_HORIZONTAL  = 2'd3
    } t_mirror;

    // Program banking modes held in control register bits 3..2.
    typedef enum logic [1:0] {
        PRG_SWAP_32K_EVEN = 2'd0,
        PRG_SWAP_32K_ODD  = 2'd1,
        PRG_FIX_FIRST     = 2'd2,
        PRG_FIX_LAST      = 2'd3
    } t_prg_mode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_PRESENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MIRRORING = 2'd3;

    typedef struct packed {
        t_op               operation;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_byte;
    } t_in_word;

    typedef struct packed {
        t_target           target;
        logic [OFFS_W-1:0] target_offset;
        logic              write_strobe;
    } t_out_word;

endpackage

// ===== rtl/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: bus access translator for banked game cartridges
// Maps CPU, pattern and nametable accesses onto external memory offsets and
// keeps the serial bank register and the bank selections.
// ----------------------------------------------------------------------------
// The result word of an accepted access word is registered.
// Throughput: one access word per cycle while the result side is ready; the result
// register frees itself in the same cycle that its word is taken.
// Reset (synchronous, active low) restores the register defaults and the bank
// state: last program bank fixed in the upper half, all other banks zero.
module cartridge_bank_mapper #(
    parameter int unsigned MAX_PRG_BANKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cbm_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cbm_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbm_pkg::COUNT_W-1:0]       i_cfg_data
);

    // Configuration registers.
    logic [1:0]                  r_mapper_kind;
    logic [cbm_pkg::COUNT_W-1:0] r_prg_bank_count;
    logic                        r_chr_rom_present;
    logic                        r_header_mirroring;

    // Bank state.
    logic [4:0] r_serial_shift, n_serial_shift;
    logic [2:0] r_serial_count, n_serial_count;
    logic [1:0] r_mirror_mode, n_mirror_mode;
    logic [1:0] r_prg_mode, n_prg_mode;
    logic       r_chr_mode, n_chr_mode;
    logic [4:0] r_chr_bank_low, n_chr_bank_low;
    logic [4:0] r_chr_bank_high, n_chr_bank_high;
    logic [7:0] r_prg_bank_lower, n_prg_bank_lower;
    logic [7:0] r_prg_bank_upper, n_prg_bank_upper;
    logic       r_upper_is_last, n_upper_is_last;

    // Result register.
    logic               r_out_valid;
    cbm_pkg::t_out_word r_out_word, n_out_word;

    logic                        in_fire;
    logic [cbm_pkg::COUNT_W-1:0] eff_count;
    logic [4:0]                  shifted;
    logic [2:0]                  count_inc;
    logic [15:0]                 addr;
    logic [7:0]                  rom_bank;
    logic [17:0]                 chr_off;
    logic [10:0]                 nt_off;
    cbm_pkg::t_mirror            mirror;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;
    assign addr        = i_in_word.bus_address;

    // Bank count clamped to the range the cartridge can hold.
    always_comb begin
        if (r_prg_bank_count == '0) begin
            eff_count = cbm_pkg::COUNT_W'(1);
        end else if (32'(r_prg_bank_count) > 32'(MAX_PRG_BANKS)) begin
            eff_count = cbm_pkg::COUNT_W'(MAX_PRG_BANKS);
        end else begin
            eff_count = r_prg_bank_count;
        end
    end

    // Program ROM bank for the addressed half of the window.
    always_comb begin
        if (r_mapper_kind == cbm_pkg::KIND_SERIAL || r_mapper_kind == cbm_pkg::KIND_SWITCH) begin
            if (addr < cbm_pkg::PRG_UPPER_BASE) begin
                rom_bank = r_prg_bank_lower;
            end else if (r_mapper_kind == cbm_pkg::KIND_SWITCH || r_upper_is_last) begin
                rom_bank = 8'(eff_count - cbm_pkg::COUNT_W'(1));
            end else begin
                rom_bank = r_prg_bank_upper;
            end
        end else begin
            rom_bank = (addr >= cbm_pkg::PRG_UPPER_BASE && eff_count > cbm_pkg::COUNT_W'(1))
                       ? 8'd1 : 8'd0;
        end
    end

    // Pattern memory offset; 4K banks only in the serial mapper. An odd low
    // bank with the full 8K window reaches past 128K, hence the extra bit.
    always_comb begin
        if (r_mapper_kind != cbm_pkg::KIND_SERIAL) begin
            chr_off = {5'd0, addr[12:0]};
        end else if (!r_chr_mode || !addr[12]) begin
            chr_off = {1'b0, r_chr_bank_low, 12'd0} + {5'd0, addr[12:0]};
        end else begin
            chr_off = {1'b0, r_chr_bank_high, addr[11:0]};
        end
    end

    // Nametable offset from the active mirroring arrangement.
    always_comb begin
        if (r_mapper_kind == cbm_pkg::KIND_SERIAL) begin
            mirror = cbm_pkg::t_mirror'(r_mirror_mode);
        end else begin
            mirror = r_header_mirroring ? cbm_pkg::MIR_VERTICAL : cbm_pkg::MIR_HORIZONTAL;
        end
        unique case (mirror)
            cbm_pkg::MIR_SINGLE_LOW:  nt_off = {1'b0, addr[9:0]};
            cbm_pkg::MIR_SINGLE_HIGH: nt_off = {1'b1, addr[9:0]};
            cbm_pkg::MIR_VERTICAL:    nt_off = addr[10:0];
            default: begin
                nt_off = {(addr >= cbm_pkg::NT_SECOND_BASE), addr[9:0]};
            end
        endcase
    end

    assign shifted   = {i_in_word.write_byte[0], r_serial_shift[4:1]};
    assign count_inc = r_serial_count + 3'd1;

    // Result word and bank state updates for the access being accepted.
    always_comb begin
        n_out_word       = '{target: cbm_pkg::TGT_NONE, target_offset: '0, write_strobe: 1'b0};
        n_serial_shift   = r_serial_shift;
        n_serial_count   = r_serial_count;
        n_mirror_mode    = r_mirror_mode;
        n_prg_mode       = r_prg_mode;
        n_chr_mode       = r_chr_mode;
        n_chr_bank_low   = r_chr_bank_low;
        n_chr_bank_high  = r_chr_bank_high;
        n_prg_bank_lower = r_prg_bank_lower;
        n_prg_bank_upper = r_prg_bank_upper;
        n_upper_is_last  = r_upper_is_last;
        unique case (i_in_word.operation)
            cbm_pkg::OP_CPU_READ, cbm_pkg::OP_CPU_WRITE: begin
                if (addr < cbm_pkg::PRG_RAM_BASE) begin
                    n_out_word.target = cbm_pkg::TGT_NONE;
                end else if (addr < cbm_pkg::PRG_ROM_BASE) begin
                    n_out_word.target        = cbm_pkg::TGT_PRG_RAM;
                    n_out_word.target_offset = {9'd0, addr[12:0]};
                    n_out_word.write_strobe  = (i_in_word.operation == cbm_pkg::OP_CPU_WRITE);
                end else if (i_in_word.operation == cbm_pkg::OP_CPU_READ) begin
                    n_out_word.target        = cbm_pkg::TGT_PRG_ROM;
                    n_out_word.target_offset = {rom_bank, addr[13:0]};
                end else if (r_mapper_kind == cbm_pkg::KIND_SWITCH) begin
                    n_prg_bank_lower = {5'd0, i_in_word.write_byte[2:0]};
                end else if (r_mapper_kind == cbm_pkg::KIND_SERIAL) begin
                    // Serial register: bit 7 resets, otherwise shift in bit 0.
                    if (i_in_word.write_byte[7]) begin
                        n_serial_shift  = '0;
                        n_serial_count  = '0;
                        n_prg_mode      = cbm_pkg::PRG_FIX_LAST;
                        n_upper_is_last = 1'b1;
                    end else if (count_inc < cbm_pkg::SERIAL_LOADS) begin
                        n_serial_shift = shifted;
                        n_serial_count = count_inc;
                    end else begin
                        n_serial_shift = '0;
                        n_serial_count = '0;
                        unique case (cbm_pkg::t_sreg'(addr[14:13]))
                            cbm_pkg::SREG_CONTROL: begin
                                n_mirror_mode = shifted[1:0];
                                n_prg_mode    = shifted[3:2];
                                n_chr_mode    = shifted[4];
                            end
                            cbm_pkg::SREG_CHR_LOW: begin
                                n_chr_bank_low = r_chr_mode ? shifted : {shifted[4:1], 1'b0};
                            end
                            cbm_pkg::SREG_CHR_HIGH: begin
                                n_chr_bank_high = shifted;
                            end
                            default: begin
                                // Loads naming a bank past the count are dropped.
                                if ({5'd0, shifted[3:0]} < eff_count) begin
                                    if (r_prg_mode <= cbm_pkg::PRG_SWAP_32K_ODD) begin
                                        n_prg_bank_lower = {4'd0, shifted[3:1], 1'b0};
                                        n_prg_bank_upper = {4'd0, shifted[3:1], 1'b1};
                                        n_upper_is_last  = 1'b0;
                                    end else if (r_prg_mode == cbm_pkg::PRG_FIX_FIRST) begin
                                        n_prg_bank_lower = '0;
                                        n_prg_bank_upper = {4'd0, shifted[3:0]};
                                        n_upper_is_last  = 1'b0;
                                    end else begin
                                        n_prg_bank_lower = {4'd0, shifted[3:0]};
                                        n_upper_is_last  = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            cbm_pkg::OP_PPU_READ, cbm_pkg::OP_PPU_WRITE: begin
                if (addr < cbm_pkg::CHR_LIMIT) begin
                    n_out_word.target        = r_chr_rom_present ? cbm_pkg::TGT_CHR_ROM
                                                                 : cbm_pkg::TGT_CHR_RAM;
                    n_out_word.target_offset = {4'd0, chr_off};
                    n_out_word.write_strobe  = (i_in_word.operation == cbm_pkg::OP_PPU_WRITE)
                                               && !r_chr_rom_present;
                end
            end
            cbm_pkg::OP_NT_LOOKUP: begin
                n_out_word.target        = cbm_pkg::TGT_NT_RAM;
                n_out_word.target_offset = {11'd0, nt_off};
            end
            default: begin
                n_out_word.target = cbm_pkg::TGT_NONE;
            end
        endcase
    end

    // Configuration and bank state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_kind      <= cbm_pkg::KIND_FIXED;
            r_prg_bank_count   <= cbm_pkg::COUNT_W'(2);
            r_chr_rom_present  <= 1'b1;
            r_header_mirroring <= 1'b0;
            r_serial_shift     <= '0;
            r_serial_count     <= '0;
            r_mirror_mode      <= '0;
            r_prg_mode         <= cbm_pkg::PRG_FIX_LAST;
            r_chr_mode         <= 1'b0;
            r_chr_bank_low     <= '0;
            r_chr_bank_high    <= '0;
            r_prg_bank_lower   <= '0;
            r_prg_bank_upper   <= '0;
            r_upper_is_last    <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    cbm_pkg::CFG_MAPPER_KIND:     r_mapper_kind <= i_cfg_data[1:0];
                    cbm_pkg::CFG_PRG_BANK_COUNT:  r_prg_bank_count <= i_cfg_data;
                    cbm_pkg::CFG_CHR_ROM_PRESENT: r_chr_rom_present <= i_cfg_data[0];
                    default:                      r_header_mirroring <= i_cfg_data[0];
                endcase
            end
            if (in_fire) begin
                r_serial_shift   <= n_serial_shift;
                r_serial_count   <= n_serial_count;
                r_mirror_mode    <= n_mirror_mode;
                r_prg_mode       <= n_prg_mode;
                r_chr_mode       <= n_chr_mode;
                r_chr_bank_low   <= n_chr_bank_low;
                r_chr_bank_high  <= n_chr_bank_high;
                r_prg_bank_lower <= n_prg_bank_lower;
                r_prg_bank_upper <= n_prg_bank_upper;
                r_upper_is_last  <= n_upper_is_last;
            end
        end
    end

    // Result register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result word payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cartridge bank mapper
// Drives access words and register writes through the valid/ready channels,
// predicts every result word from a behavioral model of the mapper state and
// compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MAX_PRG_BANKS  = 256;
    localparam int unsigned PRG_BANK_BYTES = 16384;
    localparam int unsigned CHR_BANK_BYTES = 4096;
    localparam int unsigned PHASE_ITEMS    = 80;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned CYCLE_LIMIT    = 100000;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Codes outside the package enums that the mapper must still tolerate.
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
    localparam logic [1:0] KIND_RESERVED     = 2'd3;

    // Tracks the mapper registers and the result words still to arrive.
    class mapper_scoreboard;
        logic [1:0]          kind;
        logic [8:0]          bank_count;
        logic                chr_rom;
        logic                hdr_vertical;
        logic [4:0]          shift_reg;
        logic [2:0]          shift_cnt;
        cbm_pkg::t_mirror    mirror;
        cbm_pkg::t_prg_mode  prg_mode;
        logic                chr_4k;
        logic [4:0]          chr_low;
        logic [4:0]          chr_high;
        logic [7:0]          prg_lower;
        logic [7:0]          prg_upper;
        logic                upper_last;
        cbm_pkg::t_out_word  pending[$];
        int unsigned         mismatches;

        function new();
            kind         = cbm_pkg::KIND_FIXED;
            bank_count   = 9'd2;
            chr_rom      = 1'b1;
            hdr_vertical = 1'b0;
            shift_reg    = '0;
            shift_cnt    = '0;
            mirror       = cbm_pkg::MIR_SINGLE_LOW;
            prg_mode     = cbm_pkg::PRG_FIX_LAST;
            chr_4k       = 1'b0;
            chr_low      = '0;
            chr_high     = '0;
            prg_lower    = '0;
            prg_upper    = '0;
            upper_last   = 1'b1;
            mismatches   = 0;
        endfunction

        // A bank count of zero acts as one; counts above the maximum saturate.
        function int unsigned usable_banks();
            if (bank_count == 0) return 1;
            if (bank_count > MAX_PRG_BANKS) return MAX_PRG_BANKS;
            return bank_count;
        endfunction

        function void note_config(logic [cbm_pkg::CFG_IDX_W-1:0] index,
                                  logic [cbm_pkg::COUNT_W-1:0] data);
            case (index)
                cbm_pkg::CFG_MAPPER_KIND:      kind = data[1:0];
                cbm_pkg::CFG_PRG_BANK_COUNT:   bank_count = data;
                cbm_pkg::CFG_CHR_ROM_PRESENT:  chr_rom = data[0];
                cbm_pkg::CFG_HEADER_MIRRORING: hdr_vertical = data[0];
                default: ;
            endcase
        endfunction

        // Computes the result of one access word and applies its register side effects.
        function void note_input(cbm_pkg::t_in_word w);
            cbm_pkg::t_out_word         exp;
            int unsigned                off;
            int unsigned                banks;
            int unsigned                bank;
            int unsigned                bmod;
            cbm_pkg::t_mirror           nt_mode;
            logic [cbm_pkg::ADDR_W-1:0] a;
            a     = w.bus_address;
            exp   = '0;
            off   = 0;
            bank  = 0;
            banks = usable_banks();
            case (w.operation)
                cbm_pkg::OP_CPU_READ, cbm_pkg::OP_CPU_WRITE: begin
                    if (a >= cbm_pkg::PRG_ROM_BASE && w.operation == cbm_pkg::OP_CPU_WRITE) begin
                        // Writes into the ROM window reach the mapper registers only.
                        if (kind == cbm_pkg::KIND_SWITCH) begin
                            prg_lower = {5'b0, w.write_byte[2:0]};
                        end else if (kind == cbm_pkg::KIND_SERIAL && w.write_byte[7]) begin
                            shift_reg  = '0;
                            shift_cnt  = '0;
                            prg_mode   = cbm_pkg::PRG_FIX_LAST;
                            upper_last = 1'b1;
                        end else if (kind == cbm_pkg::KIND_SERIAL) begin
                            shift_reg = {w.write_byte[0], shift_reg[4:1]};
                            shift_cnt = shift_cnt + 3'd1;
                            if (shift_cnt >= cbm_pkg::SERIAL_LOADS) begin
                                case (cbm_pkg::t_sreg'(a[14:13]))
                                    cbm_pkg::SREG_CONTROL: begin
                                        mirror   = cbm_pkg::t_mirror'(shift_reg[1:0]);
                                        prg_mode = cbm_pkg::t_prg_mode'(shift_reg[3:2]);
                                        chr_4k   = shift_reg[4];
                                    end
                                    cbm_pkg::SREG_CHR_LOW: begin
                                        chr_low = chr_4k ? shift_reg : {shift_reg[4:1], 1'b0};
                                    end
                                    cbm_pkg::SREG_CHR_HIGH: begin
                                        chr_high = shift_reg;
                                    end
                                    default: begin
                                        // A program bank at or beyond the count is dropped.
                                        bmod = {shift_reg[3:1], 1'b0};
                                        bank = shift_reg[3:0];
                                        if (bmod < banks && bank < banks) begin
                                            case (prg_mode)
                                                cbm_pkg::PRG_SWAP_32K_EVEN,
                                                cbm_pkg::PRG_SWAP_32K_ODD: begin
                                                    prg_lower  = 8'(bmod);
                                                    prg_upper  = 8'(bmod + 1);
                                                    upper_last = 1'b0;
                                                end
                                                cbm_pkg::PRG_FIX_FIRST: begin
                                                    prg_lower  = '0;
                                                    prg_upper  = 8'(bank);
                                                    upper_last = 1'b0;
                                                end
                                                default: begin
                                                    prg_lower  = 8'(bank);
                                                    upper_last = 1'b1;
                                                end
                                            endcase
                                        end
                                    end
                                endcase
                                shift_reg = '0;
                                shift_cnt = '0;
                            end
                        end
                    end else if (a >= cbm_pkg::PRG_ROM_BASE) begin
                        exp.target = cbm_pkg::TGT_PRG_ROM;
                        if (kind == cbm_pkg::KIND_SERIAL || kind == cbm_pkg::KIND_SWITCH) begin
                            if (a < cbm_pkg::PRG_UPPER_BASE) bank = prg_lower;
                            else if (kind == cbm_pkg::KIND_SWITCH || upper_last) bank = banks - 1;
                            else bank = prg_upper;
                        end else begin
                            bank = (a >= cbm_pkg::PRG_UPPER_BASE && banks > 1) ? 1 : 0;
                        end
                        off = bank * PRG_BANK_BYTES + a[13:0];
                    end else if (a >= cbm_pkg::PRG_RAM_BASE) begin
                        exp.target       = cbm_pkg::TGT_PRG_RAM;
                        exp.write_strobe = (w.operation == cbm_pkg::OP_CPU_WRITE);
                        off              = a[12:0];
                    end
                end
                cbm_pkg::OP_PPU_READ, cbm_pkg::OP_PPU_WRITE: begin
                    if (a < cbm_pkg::CHR_LIMIT) begin
                        exp.target       = chr_rom ? cbm_pkg::TGT_CHR_ROM : cbm_pkg::TGT_CHR_RAM;
                        exp.write_strobe = (w.operation == cbm_pkg::OP_PPU_WRITE) && !chr_rom;
                        if (kind != cbm_pkg::KIND_SERIAL)
                            off = a;
                        else if (!chr_4k || a < CHR_BANK_BYTES)
                            off = chr_low * CHR_BANK_BYTES + a;
                        else
                            off = chr_high * CHR_BANK_BYTES + a - CHR_BANK_BYTES;
                    end
                end
                cbm_pkg::OP_NT_LOOKUP: begin
                    exp.target = cbm_pkg::TGT_NT_RAM;
                    if (kind == cbm_pkg::KIND_SERIAL) nt_mode = mirror;
                    else nt_mode = hdr_vertical ? cbm_pkg::MIR_VERTICAL : cbm_pkg::MIR_HORIZONTAL;
                    case (nt_mode)
                        cbm_pkg::MIR_SINGLE_LOW:  off = a[9:0];
                        cbm_pkg::MIR_SINGLE_HIGH: off = {1'b1, a[9:0]};
                        cbm_pkg::MIR_VERTICAL:    off = a[10:0];
                        default: off = (a < cbm_pkg::NT_SECOND_BASE) ? a[9:0] : {1'b1, a[9:0]};
                    endcase
                end
                default: ;
            endcase
            exp.target_offset = off[cbm_pkg::OFFS_W-1:0];
            pending.push_back(exp);
        endfunction

        function void check_result(cbm_pkg::t_out_word got);
            cbm_pkg::t_out_word exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: target %0d offset 0x%06h strobe %0b",
                             got.target, got.target_offset, got.write_strobe);
                return;
            end
            exp = pending.pop_front();
            if (got.target !== exp.target || got.target_offset !== exp.target_offset ||
                got.write_strobe !== exp.write_strobe) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected target %0d offset 0x%06h ",
                              "strobe %0b, got target %0d offset 0x%06h strobe %0b"},
                             exp.target, exp.target_offset, exp.write_strobe,
                             got.target, got.target_offset, got.write_strobe);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    cbm_pkg::t_in_word               i_in_word   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    cbm_pkg::t_out_word              o_out_word;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cbm_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [cbm_pkg::COUNT_W-1:0]     i_cfg_data  = '0;

    mapper_scoreboard   sb = new();
    bit                 src_idle_on = 1'b1;
    bit                 snk_idle_on = 1'b1;
    int unsigned        items_sent  = 0;
    int unsigned        cycle_count = 0;

    cartridge_bank_mapper #(
        .MAX_PRG_BANKS(MAX_PRG_BANKS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cartridge_bank_mapper verification failed");
            $finish;
        end
    end

    // Every handshake is observed here, on the values present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.note_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_word);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_word);
        end
    end

    // Result side: a random stall before each word is taken.
    initial begin
        int unsigned stall;
        wait (i_rst_n);
        forever begin
            stall = snk_idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic cbm_pkg::t_in_word make_word(logic [2:0] op,
                                                    logic [cbm_pkg::ADDR_W-1:0] addr,
                                                    logic [cbm_pkg::DATA_W-1:0] data);
        return cbm_pkg::t_in_word'({op, addr, data});
    endfunction

    // Random access word; without mapper_writes no CPU write reaches the ROM window.
    function automatic cbm_pkg::t_in_word random_access(bit mapper_writes);
        logic [31:0]                r;
        logic [cbm_pkg::ADDR_W-1:0] a;
        logic [2:0]                 op;
        int unsigned                sel;
        r   = $urandom;
        a   = r[15:0];
        sel = $urandom_range(0, 19);
        if (sel < 9) begin
            op = (sel < 6) ? cbm_pkg::OP_CPU_READ : cbm_pkg::OP_CPU_WRITE;
            if (r[17:16] == 2'd1) a[15:13] = 3'b011;
            else if (r[17]) a[15] = 1'b1;
            if (op == cbm_pkg::OP_CPU_WRITE && !mapper_writes) a[15] = 1'b0;
        end else if (sel < 15) begin
            op = (sel < 12) ? cbm_pkg::OP_PPU_READ : cbm_pkg::OP_PPU_WRITE;
            if (r[19:18] != 2'd0) a[15:13] = 3'b000;
        end else if (sel < 19) begin
            op = cbm_pkg::OP_NT_LOOKUP;
            if (r[19:18] != 2'd0) a[15:12] = 4'h2;
        end else begin
            op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        end
        return make_word(op, a, r[31:24]);
    endfunction

    // Offers one access word after a random gap and returns once it is taken.
    task automatic send_access(input cbm_pkg::t_in_word w);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Stops the access stream and waits until all result words are back.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [cbm_pkg::CFG_IDX_W-1:0] index,
                             input logic [cbm_pkg::COUNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_config(input logic [1:0] kind, input logic [cbm_pkg::COUNT_W-1:0] count,
                               input logic chr_rom, input logic vertical);
        cfg_write(cbm_pkg::CFG_MAPPER_KIND, {7'b0, kind});
        cfg_write(cbm_pkg::CFG_PRG_BANK_COUNT, count);
        cfg_write(cbm_pkg::CFG_CHR_ROM_PRESENT, {8'b0, chr_rom});
        cfg_write(cbm_pkg::CFG_HEADER_MIRRORING, {8'b0, vertical});
        i_cfg_valid <= 1'b0;
    endtask

    // One configuration followed by random traffic; the serial mapper gets
    // mostly complete five-write loads with other accesses mixed in.
    task automatic run_phase(input logic [1:0] kind, input logic [cbm_pkg::COUNT_W-1:0] count,
                             input logic chr_rom, input logic vertical);
        int unsigned goal;
        logic [1:0]  dest;
        logic [31:0] r;
        int          k;
        settle();
        load_config(kind, count, chr_rom, vertical);
        src_idle_on = ($urandom_range(0, 3) != 0);
        snk_idle_on = ($urandom_range(0, 3) != 0);
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) begin
            if (kind == cbm_pkg::KIND_SERIAL && $urandom_range(0, 3) != 0) begin
                dest = 2'($urandom_range(0, 3));
                for (k = 0; k < cbm_pkg::SERIAL_LOADS; k++) begin
                    r = $urandom;
                    send_access(make_word(cbm_pkg::OP_CPU_WRITE, {1'b1, dest, r[12:0]},
                                          {1'b0, r[30:24]}));
                    if ($urandom_range(0, 2) == 0) send_access(random_access(1'b0));
                end
                repeat ($urandom_range(1, 3)) send_access(random_access(1'b0));
            end else begin
                send_access(random_access(1'b1));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fixed banks with the reset configuration: address map edges.
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'h0000, 8'h00));   // open bus
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'h5FFF, 8'h00));   // last open address
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'h6000, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'h7FFF, 8'hFF));  // program RAM store
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'h8000, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'hC000, 8'h00));   // second fixed bank
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'hFFFF, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'h8000, 8'h80));  // ignored by fixed banks
        send_access(make_word(cbm_pkg::OP_PPU_READ, 16'h0000, 8'h00));
        send_access(make_word(cbm_pkg::OP_PPU_WRITE, 16'h1FFF, 8'h5A));  // pattern ROM, no store
        send_access(make_word(cbm_pkg::OP_PPU_READ, 16'h2000, 8'h00));   // beyond pattern space
        send_access(make_word(cbm_pkg::OP_NT_LOOKUP, 16'h2000, 8'h00));
        send_access(make_word(cbm_pkg::OP_NT_LOOKUP, 16'h2800, 8'h00));  // second horizontal table
        send_access(make_word(cbm_pkg::OP_NT_LOOKUP, 16'hFFFF, 8'h00));
        send_access(make_word(OP_RESERVED_FIRST, 16'hFFFF, 8'hFF));
        send_access(make_word(OP_RESERVED_LAST, 16'h1234, 8'h00));

        // Serial mapper with a zero bank count: reset mid-load, then a
        // program bank load of bank one that the single usable bank rejects.
        settle();
        load_config(cbm_pkg::KIND_SERIAL, 9'd0, 1'b0, 1'b1);
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h01));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'h8000, 8'h80));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h01));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_WRITE, 16'hE000, 8'h00));
        send_access(make_word(cbm_pkg::OP_CPU_READ, 16'h8000, 8'h00));
        send_access(make_word(cbm_pkg::OP_PPU_WRITE, 16'h0010, 8'hAA));  // pattern RAM store

        // Random traffic over a spread of configurations, extremes included.
        run_phase(cbm_pkg::KIND_SERIAL, 9'd16, 1'b0, 1'b1);
        run_phase(cbm_pkg::KIND_SERIAL, 9'd511, 1'b1, 1'b0);
        run_phase(cbm_pkg::KIND_SERIAL, 9'd1, 1'b0, 1'b0);
        run_phase(cbm_pkg::KIND_SWITCH, 9'd8, 1'b0, 1'b1);
        run_phase(cbm_pkg::KIND_SWITCH, 9'd256, 1'b1, 1'b0);
        run_phase(cbm_pkg::KIND_FIXED, 9'd1, 1'b0, 1'b1);
        run_phase(KIND_RESERVED, 9'd256, 1'b1, 1'b1);
        run_phase(cbm_pkg::KIND_SERIAL, 9'd3, 1'b0, 1'b0);
        settle();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("cartridge_bank_mapper verification clean");
        else
            $display("cartridge_bank_mapper verification failed");
        $finish;
    end

endmodule
